[hw/rtl/sshr_pkg.sv]
package sshr_pkg;
  localparam int ROWS = 3;
  localparam int SEGS = 2;
  localparam int REGS_PER_BUCKET = 4;
  localparam int VREGS = 8;
  localparam int RANK_W = 5;
  localparam int SEED_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SEED = 3'd6;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [31:0] ALPHA_L2_NUM = 32'd1846528;
  localparam logic [15:0] ALPHA_DEN = 16'd45395;

  typedef struct packed {
    logic        opcode;
    logic [31:0] flow_key;
    logic [31:0] element;
  } item_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] flow_key;
    logic [1:0]  reg_idx;
    logic        seg;
    logic [RANK_W-1:0] rank;
  } cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] lin_count(input logic [3:0] z);
    case (z)
      4'd0: lin_count = 32'd16;
      4'd1: lin_count = 32'd16;
      4'd2: lin_count = 32'd11;
      4'd3: lin_count = 32'd7;
      4'd4: lin_count = 32'd5;
      4'd5: lin_count = 32'd3;
      4'd6: lin_count = 32'd2;
      4'd7: lin_count = 32'd1;
      default: lin_count = 32'd0;
    endcase
  endfunction
endpackage

[hw/rtl/sshr_stream_if.sv]
interface sshr_stream_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/spread_sketch_hll_min_rows.sv]
// Channel | Direction | Payload
// in      | sink      | opcode, flow_key, element
// out     | source    | spread_estimate
// cfg     | write     | cfg_index, cfg_data
// After reset all 4*BUCKETS_PER_ROW entries of each row's store are cleared before items flow.
// An update runs three serial key hashes and then three read-modify-writes.
// A query runs six key hashes, 24 reads and a 63-step divider.
// Reset is synchronous, active low; each side stalls on its own through a two-entry queue.
module spread_sketch_hll_min_rows #(
  parameter int BUCKETS_PER_ROW = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_opcode,
  input  logic [31:0] in_flow_key,
  input  logic [31:0] in_element,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] out_spread_estimate,
  input  logic cfg_we,
  input  logic [sshr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sshr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sshr_pkg::*;
  logic [ROWS*SEGS*SEED_W-1:0] seeds_r;
  logic [31:0] eseed_r;
  sshr_stream_if #($bits(item_t)) in_ch();
  sshr_stream_if #($bits(cmd_t)) c0();
  sshr_stream_if #($bits(cmd_t)) c1();
  sshr_stream_if #(32) o_ch();

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS*SEGS; i++) seeds_r[i*SEED_W +: SEED_W] <= SEED_W'(i);
      eseed_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < CFG_ELEMENT_SEED) seeds_r[cfg_index*SEED_W +: SEED_W] <= cfg_data[SEED_W-1:0];
      else if (cfg_index == CFG_ELEMENT_SEED) eseed_r <= cfg_data;
    end
  end

  assign in_ch.valid = in_valid;
  assign in_ready = in_ch.ready;
  assign in_ch.data = {in_opcode, in_flow_key, in_element};

  sshr_front u_front (.clk(clk), .rst_n(rst_n), .element_seed(eseed_r), .in_ch(in_ch.sink),
    .cmd_ch(c0.source));
  sshr_queue u_queue (.clk(clk), .rst_n(rst_n), .q_in(c0.sink), .q_out(c1.source));
  sshr_back #(.BUCKETS_PER_ROW(BUCKETS_PER_ROW)) u_back (.clk(clk), .rst_n(rst_n),
    .key_seeds(seeds_r), .cmd_ch(c1.sink), .out_ch(o_ch.source));

  assign out_valid = o_ch.valid;
  assign out_spread_estimate = o_ch.data;
  assign o_ch.ready = out_ready;
endmodule

[hw/rtl/sshr_ram.sv]
module sshr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/sshr_murmur.sv]
module sshr_murmur (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] word,
  input  logic [31:0] seed,
  output logic        done,
  output logic [31:0] hash
);
  import sshr_pkg::*;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] h_r, h_nxt, k_r, k_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] t;

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    h_nxt = h_r;
    k_nxt = k_r;
    t = '0;
    if (start) begin
      k_nxt = word * 32'hcc9e2d51;
      h_nxt = seed;
      step_nxt = 3'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      case (step_r)
        3'd1: k_nxt = rotl32(k_r, 15) * 32'h1b873593;
        3'd2: begin
          t = rotl32(h_r ^ k_r, 13);
          h_nxt = (t << 2) + t + 32'he6546b64;
        end
        3'd3: begin
          t = h_r ^ 32'd4;
          h_nxt = (t ^ (t >> 16)) * 32'h85ebca6b;
        end
        3'd4: begin
          h_nxt = (h_r ^ (h_r >> 13)) * 32'hc2b2ae35;
        end
        3'd5: begin
          h_nxt = h_r ^ (h_r >> 16);
          busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
    h_r <= h_nxt;
    k_r <= k_nxt;
  end

  assign done = busy_r && (step_r == 3'd5);
  assign hash = h_r ^ (h_r >> 16);
endmodule

[hw/rtl/sshr_front.sv]
module sshr_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] element_seed,
  sshr_stream_if.sink   in_ch,
  sshr_stream_if.source cmd_ch
);
  import sshr_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0, S_HASH = 2'd1, S_OUT = 2'd2;
  logic [1:0] state_r, state_nxt;
  item_t in_item;
  cmd_t  cmd_r, cmd_nxt;
  logic  start, done;
  logic [31:0] h;
  logic [RANK_W-1:0] len;

  assign in_item = item_t'(in_ch.data);
  assign in_ch.ready = (state_r == S_IDLE);
  assign start = in_ch.valid && in_ch.ready && (in_item.opcode == OP_UPDATE);

  sshr_murmur u_hash (.clk(clk), .rst_n(rst_n), .start(start), .word(in_item.element),
    .seed(element_seed), .done(done), .hash(h));

  always_comb begin
    len = '0;
    for (int i = 0; i < 30; i++) begin
      if (h[i]) len = RANK_W'(i + 1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        cmd_nxt.opcode = in_item.opcode;
        cmd_nxt.flow_key = in_item.flow_key;
        cmd_nxt.reg_idx = '0;
        cmd_nxt.seg = 1'b0;
        cmd_nxt.rank = '0;
        state_nxt = (in_item.opcode == OP_UPDATE) ? S_HASH : S_OUT;
      end
      S_HASH: if (done) begin
        cmd_nxt.reg_idx = h[31:30];
        cmd_nxt.seg = h[2];
        cmd_nxt.rank = RANK_W'(31) - len;
        state_nxt = S_OUT;
      end
      S_OUT: if (cmd_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_ch.valid = (state_r == S_OUT);
  assign cmd_ch.data = cmd_r;
endmodule

[hw/rtl/sshr_queue.sv]
module sshr_queue (
  input logic clk,
  input logic rst_n,
  sshr_stream_if.sink   q_in,
  sshr_stream_if.source q_out
);
  import sshr_pkg::*;
  cmd_t mem_r [2];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;
  assign q_in.ready = (cnt_r != 2'd2);
  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.data = mem_r[rp_r];
  assign push = q_in.valid && q_in.ready;
  assign pop = q_out.valid && q_out.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= q_in.data;
  end
endmodule

[hw/rtl/sshr_back.sv]
module sshr_back #(
  parameter int BUCKETS_PER_ROW = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [sshr_pkg::ROWS*sshr_pkg::SEGS*sshr_pkg::SEED_W-1:0] key_seeds,
  sshr_stream_if.sink   cmd_ch,
  sshr_stream_if.source out_ch
);
  import sshr_pkg::*;
  localparam int DEPTH = BUCKETS_PER_ROW * REGS_PER_BUCKET;
  localparam int AW = $clog2(DEPTH);
  localparam int BW = $clog2(BUCKETS_PER_ROW);
  localparam int CW = AW + 1;
  localparam int RS = 32 + BW;
  localparam logic [32:0] RECIP_M =
    33'(((64'd1 << RS) + 64'(BUCKETS_PER_ROW) - 64'd1) / 64'(BUCKETS_PER_ROW));

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_KH = 4'd2, S_MOD = 4'd3,
    S_RD = 4'd4, S_RW = 4'd5, S_WR = 4'd6, S_QRD = 4'd7, S_QWT = 4'd8, S_QACC = 4'd9,
    S_SUM = 4'd10, S_DEN = 4'd11, S_DIV = 4'd12, S_OUT = 4'd13;

  logic [3:0] state_r, state_nxt;
  cmd_t cmd_r;
  cmd_t cmd_in;
  logic [CW-1:0] clr_r;
  logic [1:0] row_r;
  logic seg_r;
  logic [1:0] reg_r;
  logic [BW-1:0] bkt_r [ROWS];
  logic [31:0] kh_r;
  logic [64:0] prod_r;
  logic [RANK_W-1:0] v_r [VREGS];
  logic [34:0] sum_r;
  logic [3:0] zeros_r;
  logic [50:0] den_r;
  logic [63:0] rem_r;
  logic [62:0] num_sh_r;
  logic [6:0] dcnt_r;
  logic [33:0] quo_r;
  logic [31:0] est_val;
  logic hs_start, hs_done;
  logic [31:0] hs_hash;
  logic [SEED_W-1:0] seed_sel;
  logic [BW-1:0] bkt_mod;

  logic we [ROWS];
  logic [AW-1:0] waddr, raddr [ROWS];
  logic [RANK_W-1:0] wdata, rdata [ROWS];

  assign cmd_in = cmd_t'(cmd_ch.data);
  assign seed_sel = key_seeds[(row_r*SEGS + 32'(seg_r))*SEED_W +: SEED_W];
  sshr_murmur u_khash (.clk(clk), .rst_n(rst_n), .start(hs_start), .word(cmd_r.flow_key),
    .seed({{(32-SEED_W){1'b0}}, seed_sel}), .done(hs_done), .hash(hs_hash));

  // The bucket is the key hash minus the reciprocal-estimated quotient times the bucket count.
  always_comb begin
    logic [31:0] quot;
    quot = 32'(prod_r >> RS);
    bkt_mod = BW'(kh_r) - BW'(quot) * BW'(BUCKETS_PER_ROW);
  end

  for (genvar g = 0; g < ROWS; g++) begin : g_row
    sshr_ram #(.WIDTH(RANK_W), .DEPTH(DEPTH)) u_ram (.clk(clk), .we(we[g]), .waddr(waddr),
      .wdata(wdata), .raddr(raddr[g]), .rdata(rdata[g]));
    assign raddr[g] = {bkt_r[g], (state_r == S_RD || state_r == S_RW) ? cmd_r.reg_idx : reg_r};
  end

  always_comb begin
    for (int g = 0; g < ROWS; g++) we[g] = 1'b0;
    waddr = {bkt_r[0], cmd_r.reg_idx};
    wdata = cmd_r.rank;
    if (state_r == S_CLEAR) begin
      for (int g = 0; g < ROWS; g++) we[g] = 1'b1;
      waddr = AW'(clr_r);
      wdata = '0;
    end else if (state_r == S_WR) begin
      we[row_r] = rdata[row_r] < cmd_r.rank;
      waddr = {bkt_r[row_r], cmd_r.reg_idx};
    end
  end

  always_comb begin
    if (quo_r < 34'd20 || (quo_r == 34'd20 && rem_r == '0)) est_val = lin_count(zeros_r);
    else if (quo_r[33:32] != 2'd0) est_val = '1;
    else est_val = quo_r[31:0];
  end

  assign hs_start = (state_r == S_KH);
  assign cmd_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = est_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (cmd_ch.valid) begin
          cmd_r <= cmd_in;
          row_r <= '0;
          seg_r <= (cmd_in.opcode == OP_UPDATE) ? cmd_in.seg : 1'b0;
          state_r <= S_KH;
        end
        S_KH: state_r <= S_MOD;
        S_MOD: if (hs_done) begin
          kh_r <= hs_hash;
          prod_r <= 65'(hs_hash) * 65'(RECIP_M);
          state_r <= S_RD;
        end
        S_RD: begin
          bkt_r[row_r] <= bkt_mod;
          if (row_r == 2'(ROWS - 1)) begin
            row_r <= '0;
            reg_r <= '0;
            state_r <= (cmd_r.opcode == OP_UPDATE) ? S_RW : S_QRD;
          end else begin
            row_r <= row_r + 2'd1;
            state_r <= S_KH;
          end
        end
        S_RW: state_r <= S_WR;
        S_WR: begin
          if (row_r == 2'(ROWS - 1)) state_r <= S_IDLE;
          else begin
            row_r <= row_r + 2'd1;
            state_r <= S_RW;
          end
        end
        S_QRD: state_r <= S_QWT;
        S_QWT: state_r <= S_QACC;
        S_QACC: begin
          logic [RANK_W-1:0] m;
          m = rdata[0];
          if (rdata[1] < m) m = rdata[1];
          if (rdata[2] < m) m = rdata[2];
          v_r[{seg_r, reg_r}] <= m;
          reg_r <= reg_r + 2'd1;
          if (reg_r != 2'd3) state_r <= S_QRD;
          else if (!seg_r) begin
            seg_r <= 1'b1;
            row_r <= '0;
            state_r <= S_KH;
          end else state_r <= S_SUM;
        end
        S_SUM: begin
          logic [34:0] s;
          logic [3:0] z;
          s = '0;
          z = '0;
          for (int i = 0; i < VREGS; i++) begin
            s = s + (35'd1 << (31 - v_r[i]));
            if (v_r[i] == '0) z = z + 4'd1;
          end
          sum_r <= s;
          zeros_r <= z;
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r <= 51'(sum_r) * 51'(ALPHA_DEN);
          num_sh_r <= 63'(ALPHA_L2_NUM) << 31;
          rem_r <= '0;
          quo_r <= '0;
          dcnt_r <= 7'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          logic [64:0] r2;
          r2 = {rem_r, num_sh_r[62]};
          num_sh_r <= num_sh_r << 1;
          if (r2 >= 65'(den_r)) begin
            rem_r <= 64'(r2 - 65'(den_r));
            if (dcnt_r >= 7'd29) quo_r <= {quo_r[32:0], 1'b1};
          end else begin
            rem_r <= r2[63:0];
            if (dcnt_r >= 7'd29) quo_r <= {quo_r[32:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'd62) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
